### src/bcpe_pkg.sv
// Shared types, widths and constants for the baseline charge peak extractor.
// No dependencies; every other file imports this package.
`default_nettype none

package bcpe_pkg;

    // Sample and trace geometry
    localparam int SAMPLE_W         = 12;
    localparam int BASELINE_SAMPLES = 20;
    localparam int MAX_TRACE_LENGTH = 512;
    localparam int FRACTION_BITS    = 8;

    // Sample index saturates at all ones
    localparam int INDEX_W = 10;
    localparam int LIMIT_W = INDEX_W + 1;

    // Baseline sum and divide-by-constant through a reciprocal multiply
    localparam int SUM_W       = $clog2(BASELINE_SAMPLES * (2**SAMPLE_W - 1) + 1);
    localparam int SCALED_W    = SUM_W + FRACTION_BITS;
    localparam int RECIP_SHIFT = SCALED_W + $clog2(BASELINE_SAMPLES);
    localparam int RECIP_W     = SCALED_W + 1;
    localparam int PROD_W      = SCALED_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MULT =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + BASELINE_SAMPLES - 1) / BASELINE_SAMPLES);

    // Result widths
    localparam int BASE_W   = SAMPLE_W + FRACTION_BITS;
    localparam int DIFF_W   = BASE_W + 1;
    localparam int CHARGE_W = 26;
    localparam int AMP_W    = 20;
    localparam logic [AMP_W-1:0] AMP_MAX =
        AMP_W'((2**SAMPLE_W - 1) << FRACTION_BITS);

    // Configuration registers
    localparam int WSTART_W   = 9;
    localparam int WLEN_W     = 7;
    localparam int WEND_W     = 10;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [WSTART_W-1:0] WSTART_RESET = WSTART_W'(60);
    localparam logic [WLEN_W-1:0]   WLEN_RESET   = WLEN_W'(20);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WINDOW_START  = 1'b0,
        REG_WINDOW_LENGTH = 1'b1
    } cfg_reg_t;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic [INDEX_W-1:0]  index;
    } sample_item_t;

    typedef struct packed {
        logic [WSTART_W-1:0] window_start;
        logic [WLEN_W-1:0]   window_length;
    } window_cfg_t;

endpackage

`default_nettype wire

### src/bcpe_front.sv
// Input register: one sample request per cycle unless stalled; tags it with its index.
// Depends on bcpe_pkg.
`default_nettype none

module bcpe_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [bcpe_pkg::SAMPLE_W-1:0]   in_sample,
    input  wire logic                            in_last,
    input  wire logic                            advance,
    output logic                                 accept,
    output bcpe_pkg::sample_item_t               acc_item,
    output logic                                 item_valid,
    output bcpe_pkg::sample_item_t               item
);
    import bcpe_pkg::*;

    logic               item_valid_reg;
    sample_item_t       item_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [INDEX_W-1:0] index_next;

    // Stage frees up when empty or when its item moves on this cycle
    assign in_ready = !item_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign acc_item.sample = in_sample;
    assign acc_item.last   = in_last;
    assign acc_item.index  = index_reg;

    // Index of the next sample, saturating, back to zero after the last one
    always_comb
    begin
        index_next = index_reg;
        if (accept)
        begin
            if (in_last)
                index_next = '0;
            else if (index_reg != {INDEX_W{1'b1}})
                index_next = index_reg + INDEX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg      <= '0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            index_reg <= index_next;
            if (accept)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= acc_item;
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### src/bcpe_baseline.sv
// Baseline estimator: sums the leading samples of a trace, then divides by the
// sample count with a reciprocal multiply. Depends on bcpe_pkg.
`default_nettype none

module bcpe_baseline (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire bcpe_pkg::sample_item_t        acc_item,
    output logic [bcpe_pkg::BASE_W-1:0]        baseline
);
    import bcpe_pkg::*;

    logic [SUM_W-1:0]    sum_reg;
    logic                calc_reg;
    logic [BASE_W-1:0]   baseline_reg;
    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   product;
    logic                in_base;

    assign in_base = acc_item.index < INDEX_W'(BASELINE_SAMPLES);

    // Running sum of the baseline samples; calc flags the completed sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            calc_reg <= 1'b0;
        end
        else
        begin
            calc_reg <= accept && !acc_item.last
                        && (acc_item.index == INDEX_W'(BASELINE_SAMPLES - 1));
            if (accept)
            begin
                if (acc_item.last)
                    sum_reg <= '0;
                else if (in_base)
                    sum_reg <= sum_reg + SUM_W'(acc_item.sample);
            end
        end
    end

    // floor((sum << FRACTION_BITS) / BASELINE_SAMPLES), exact over the sum range
    assign scaled  = SCALED_W'(sum_reg) << FRACTION_BITS;
    assign product = PROD_W'(scaled) * PROD_W'(RECIP_MULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            baseline_reg <= '0;
        else if (calc_reg)
            baseline_reg <= product[RECIP_SHIFT +: BASE_W];
    end

    assign baseline = baseline_reg;

endmodule

`default_nettype wire

### src/bcpe_integrator.sv
// Window integrator: charge sum, peak tracking and the result register.
// Depends on bcpe_pkg.
`default_nettype none

module bcpe_integrator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    input  wire bcpe_pkg::sample_item_t            item,
    input  wire logic [bcpe_pkg::BASE_W-1:0]       baseline,
    input  wire bcpe_pkg::window_cfg_t             win_cfg,
    output logic                                   advance,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [bcpe_pkg::CHARGE_W-1:0]   out_charge,
    output logic [bcpe_pkg::AMP_W-1:0]             out_amplitude,
    output logic                                   out_short
);
    import bcpe_pkg::*;

    logic signed [CHARGE_W-1:0] charge_reg;
    logic signed [CHARGE_W-1:0] charge_next;
    logic [AMP_W-1:0]           peak_reg;
    logic [AMP_W-1:0]           peak_next;
    logic                       out_valid_reg;
    logic signed [CHARGE_W-1:0] out_charge_reg;
    logic [AMP_W-1:0]           out_amp_reg;
    logic                       out_short_reg;

    logic [LIMIT_W-1:0]         wend;
    logic [LIMIT_W-1:0]         index_ext;
    logic [INDEX_W-1:0]         index_inc;
    logic [LIMIT_W-1:0]         got;
    logic                       in_window;
    logic [BASE_W-1:0]          held;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [CHARGE_W:0]   sum_wide;

    // Last samples wait only while an untaken result occupies the output
    assign advance = item_valid && (!item.last || !out_valid_reg || out_ready);

    // Window bounds
    assign wend      = LIMIT_W'(win_cfg.window_start) + LIMIT_W'(win_cfg.window_length);
    assign index_ext = LIMIT_W'(item.index);
    assign in_window = (index_ext < LIMIT_W'(MAX_TRACE_LENGTH))
                       && (index_ext >= LIMIT_W'(win_cfg.window_start))
                       && (index_ext < wend);

    // Baseline is zero until the current trace has produced one
    assign held = (item.index < INDEX_W'(BASELINE_SAMPLES)) ? '0 : baseline;
    assign diff = signed'(DIFF_W'(item.sample) << FRACTION_BITS) - signed'(DIFF_W'(held));

    // Saturating charge sum and peak update
    assign sum_wide = (CHARGE_W+1)'(charge_reg) + (CHARGE_W+1)'(diff);

    always_comb
    begin
        charge_next = charge_reg;
        peak_next   = peak_reg;
        if (in_window)
        begin
            if (sum_wide[CHARGE_W] != sum_wide[CHARGE_W-1])
                charge_next = sum_wide[CHARGE_W] ? {1'b1, {(CHARGE_W-1){1'b0}}}
                                                 : {1'b0, {(CHARGE_W-1){1'b1}}};
            else
                charge_next = sum_wide[CHARGE_W-1:0];
            if (diff > signed'({1'b0, peak_reg}))
                peak_next = diff[AMP_W-1:0];
        end
    end

    // Samples seen, capped at the trace limit, against the window end
    assign index_inc = (item.index == {INDEX_W{1'b1}}) ? item.index
                                                       : item.index + INDEX_W'(1);
    assign got = (LIMIT_W'(index_inc) > LIMIT_W'(MAX_TRACE_LENGTH))
                 ? LIMIT_W'(MAX_TRACE_LENGTH) : LIMIT_W'(index_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_reg    <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                if (item.last)
                begin
                    charge_reg <= '0;
                    peak_reg   <= '0;
                end
                else
                begin
                    charge_reg <= charge_next;
                    peak_reg   <= peak_next;
                end
            end
            if (advance && item.last)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && item.last)
        begin
            out_charge_reg <= charge_next;
            out_amp_reg    <= peak_next;
            out_short_reg  <= got < wend;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_charge    = out_charge_reg;
    assign out_amplitude = out_amp_reg;
    assign out_short     = out_short_reg;

endmodule

`default_nettype wire

### src/baseline_charge_peak_extractor_top.sv
// A result reaches m_tvalid once its last sample has passed the input and output registers.
// Throughput: one sample per cycle; a last sample waits in the input register only
// while the previous result has not been taken from the output register.
// The baseline divide is one reciprocal multiply, registered after the baseline window.
// Reset (rst_n, asynchronous, active low) clears the trace state and result valid and
// loads window_start = 60, window_length = 20. Uses bcpe_pkg and the bcpe_* submodules.
`default_nettype none

module baseline_charge_peak_extractor_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // sample request stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [bcpe_pkg::S_TDATA_W-1:0]      s_tdata,   // [11:0] sample
    input  wire logic                                s_tlast,   // last_sample
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [bcpe_pkg::M_TDATA_W-1:0]           m_tdata,   // [25:0] charge, [45:26] amplitude
    output logic                                     m_tuser,   // short_trace
    // configuration writes
    input  wire logic                                cfg_wr_en,
    input  wire logic [bcpe_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bcpe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import bcpe_pkg::*;

    logic [WSTART_W-1:0]        wstart_reg;
    logic [WLEN_W-1:0]          wlen_reg;
    window_cfg_t                win_cfg;
    logic                       advance;
    logic                       accept;
    sample_item_t               acc_item;
    logic                       item_valid;
    sample_item_t               item;
    logic [BASE_W-1:0]          baseline;
    logic signed [CHARGE_W-1:0] out_charge;
    logic [AMP_W-1:0]           out_amplitude;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wstart_reg <= WSTART_RESET;
            wlen_reg   <= WLEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_WINDOW_START:  wstart_reg <= cfg_wdata[WSTART_W-1:0];
                REG_WINDOW_LENGTH: wlen_reg   <= cfg_wdata[WLEN_W-1:0];
                default:           wstart_reg <= wstart_reg;
            endcase
        end
    end

    assign win_cfg.window_start  = wstart_reg;
    assign win_cfg.window_length = wlen_reg;

    bcpe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata[SAMPLE_W-1:0]),
        .in_last    (s_tlast),
        .advance    (advance),
        .accept     (accept),
        .acc_item   (acc_item),
        .item_valid (item_valid),
        .item       (item)
    );

    bcpe_baseline u_baseline (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .acc_item (acc_item),
        .baseline (baseline)
    );

    bcpe_integrator u_integrator (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .baseline      (baseline),
        .win_cfg       (win_cfg),
        .advance       (advance),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_charge    (out_charge),
        .out_amplitude (out_amplitude),
        .out_short     (m_tuser)
    );

    assign m_tdata = M_TDATA_W'({out_amplitude, out_charge});

endmodule

`default_nettype wire

### src/bcpe_checker.sv
// Port-level checks for baseline_charge_peak_extractor_top, bound to the top level.
// Depends on bcpe_pkg.
`default_nettype none

module bcpe_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [bcpe_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                                m_tuser
);
    import bcpe_pkg::*;

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // With the output register empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

    // Amplitude stays within the scaled sample range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[CHARGE_W +: AMP_W] <= AMP_MAX)
    else $error("amplitude out of range");

    // Padding bits of the result stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:CHARGE_W+AMP_W] == '0)
    else $error("result padding not zero");

endmodule

bind baseline_charge_peak_extractor_top bcpe_checker u_bcpe_checker (.*);

`default_nettype wire
